// ----- sv/dq_pkg.sv -----
// ----------------------------------------------------------------------------
// dq_pkg
// Shared sizes, operation and status codes, and controller/datapath types
// for the double-ended queue.
// ----------------------------------------------------------------------------
package dq_pkg;

    // ring size, must be a power of two so that slot arithmetic wraps freely
    localparam int CAPACITY = 1024;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // fixed payload widths
    localparam int WORD_W = 64;
    localparam int KIND_W = 3;
    localparam int POS_W  = 10;
    localparam int STS_W  = 2;

    // operation codes; the one spare code is ignored
    typedef enum logic [KIND_W-1:0] {
        K_PUSH_BACK  = 3'd0,
        K_PUSH_FRONT = 3'd1,
        K_POP_BACK   = 3'd2,
        K_POP_FRONT  = 3'd3,
        K_READ_AT    = 3'd4,
        K_WRITE_AT   = 3'd5,
        K_CLEAR      = 3'd6
    } t_kind;

    // result status codes
    typedef enum logic [STS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EXEC = 2'd1,
        S_EMIT = 2'd2
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic exec;
        logic emit;
    } t_dq_cmd;

    // datapath to controller status
    typedef struct packed {
        logic out_free;
    } t_dq_sts;

endpackage

// ----- sv/dq_in_if.sv -----
// ----------------------------------------------------------------------------
// dq_in_if
// Operation channel: valid/ready handshake carrying one queue operation.
// ----------------------------------------------------------------------------
interface dq_in_if;

    logic                       valid;
    logic                       ready;
    logic [dq_pkg::KIND_W-1:0]  kind;
    logic [dq_pkg::WORD_W-1:0]  item_value;
    logic [dq_pkg::POS_W-1:0]   position;

    modport source (output valid, kind, item_value, position, input ready);
    modport sink   (input valid, kind, item_value, position, output ready);

endinterface

// ----- sv/dq_out_if.sv -----
// ----------------------------------------------------------------------------
// dq_out_if
// Result channel: valid/ready handshake carrying one operation result.
// ----------------------------------------------------------------------------
interface dq_out_if;

    logic                       valid;
    logic                       ready;
    logic [dq_pkg::WORD_W-1:0]  result_value;
    logic [dq_pkg::STS_W-1:0]   status;
    logic [dq_pkg::CNT_W-1:0]   entry_count;
    logic                       is_empty;

    modport source (output valid, result_value, status, entry_count, is_empty, input ready);
    modport sink   (input valid, result_value, status, entry_count, is_empty, output ready);

endinterface

// ----- sv/dq_ram.sv -----
// ----------------------------------------------------------------------------
// dq_ram
// Generic single-port RAM with registered read data held between reads.
// ----------------------------------------------------------------------------
module dq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    // registered read, holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/dq_ctrl.sv -----
// ----------------------------------------------------------------------------
// dq_ctrl
// Sequencer: accept one operation, execute it, then hand the result to the
// output register.
// ----------------------------------------------------------------------------
module dq_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  dq_pkg::t_dq_sts i_sts,
    output dq_pkg::t_dq_cmd o_cmd
);

    dq_pkg::t_state r_state;
    dq_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            dq_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = dq_pkg::S_EXEC;
                end
            end
            dq_pkg::S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = dq_pkg::S_EMIT;
            end
            dq_pkg::S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = dq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dq_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/dq_dp.sv -----
// ----------------------------------------------------------------------------
// dq_dp
// Datapath: ring pointers, entry count, entry RAM and the output register.
// ----------------------------------------------------------------------------
module dq_dp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  dq_pkg::t_dq_cmd            i_cmd,
    output dq_pkg::t_dq_sts            o_sts,
    input  logic [dq_pkg::KIND_W-1:0]  i_kind,
    input  logic [dq_pkg::WORD_W-1:0]  i_item_value,
    input  logic [dq_pkg::POS_W-1:0]   i_position,
    input  logic                       i_out_ready,
    output logic                       o_out_valid,
    output logic [dq_pkg::WORD_W-1:0]  o_result_value,
    output logic [dq_pkg::STS_W-1:0]   o_status,
    output logic [dq_pkg::CNT_W-1:0]   o_entry_count,
    output logic                       o_is_empty
);

    localparam int AW = dq_pkg::ADDR_W;
    localparam int CW = dq_pkg::CNT_W;

    // latched operation
    dq_pkg::t_kind              r_kind;
    logic [dq_pkg::WORD_W-1:0]  r_item;
    logic [dq_pkg::POS_W-1:0]   r_pos;

    // ring state
    logic [AW-1:0]              r_front, n_front;
    logic [CW-1:0]              r_count, n_count;

    // per-operation outcome
    dq_pkg::t_status            r_status, n_status;
    logic                       r_rd, n_rd;

    // output register
    logic                       r_out_valid;
    logic [dq_pkg::WORD_W-1:0]  r_out_result;
    dq_pkg::t_status            r_out_status;
    logic [CW-1:0]              r_out_count;
    logic                       r_out_empty;

    // ram port
    logic                       ram_we;
    logic                       ram_re;
    logic [AW-1:0]              ram_addr;
    logic [dq_pkg::WORD_W-1:0]  ram_rdata;

    // ring decode
    logic                       full;
    logic                       empty;
    logic                       in_range;
    logic [AW-1:0]              back_slot;
    logic [AW-1:0]              last_slot;
    logic [AW-1:0]              pos_slot;
    logic [AW-1:0]              front_dec;
    logic [AW-1:0]              front_inc;

    // operation capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= dq_pkg::t_kind'(i_kind);
            r_item <= i_item_value;
            r_pos  <= i_position;
        end
    end

    // slot arithmetic wraps at the ring size
    assign full      = (r_count == CW'(dq_pkg::CAPACITY));
    assign empty     = (r_count == '0);
    assign in_range  = (CW'(r_pos) < r_count);
    assign back_slot = r_front + r_count[AW-1:0];
    assign last_slot = back_slot - AW'(1);
    assign pos_slot  = r_front + AW'(r_pos);
    assign front_dec = r_front - AW'(1);
    assign front_inc = r_front + AW'(1);

    // execute step
    always_comb begin
        n_front  = r_front;
        n_count  = r_count;
        n_status = r_status;
        n_rd     = r_rd;
        ram_we   = 1'b0;
        ram_re   = 1'b0;
        ram_addr = r_front;
        if (i_cmd.exec) begin
            n_status = dq_pkg::ST_OK;
            n_rd     = 1'b0;
            unique case (r_kind)
                dq_pkg::K_PUSH_BACK: begin
                    if (full) begin
                        n_status = dq_pkg::ST_FULL;
                    end else begin
                        ram_we   = 1'b1;
                        ram_addr = back_slot;
                        n_count  = r_count + CW'(1);
                    end
                end
                dq_pkg::K_PUSH_FRONT: begin
                    if (full) begin
                        n_status = dq_pkg::ST_FULL;
                    end else begin
                        ram_we   = 1'b1;
                        ram_addr = front_dec;
                        n_front  = front_dec;
                        n_count  = r_count + CW'(1);
                    end
                end
                dq_pkg::K_POP_BACK: begin
                    if (empty) begin
                        n_status = dq_pkg::ST_EMPTY;
                    end else begin
                        ram_re   = 1'b1;
                        ram_addr = last_slot;
                        n_rd     = 1'b1;
                        n_count  = r_count - CW'(1);
                    end
                end
                dq_pkg::K_POP_FRONT: begin
                    if (empty) begin
                        n_status = dq_pkg::ST_EMPTY;
                    end else begin
                        ram_re   = 1'b1;
                        ram_addr = r_front;
                        n_rd     = 1'b1;
                        n_front  = front_inc;
                        n_count  = r_count - CW'(1);
                    end
                end
                dq_pkg::K_READ_AT: begin
                    if (!in_range) begin
                        n_status = dq_pkg::ST_RANGE;
                    end else begin
                        ram_re   = 1'b1;
                        ram_addr = pos_slot;
                        n_rd     = 1'b1;
                    end
                end
                dq_pkg::K_WRITE_AT: begin
                    if (!in_range) begin
                        n_status = dq_pkg::ST_RANGE;
                    end else begin
                        ram_we   = 1'b1;
                        ram_addr = pos_slot;
                    end
                end
                dq_pkg::K_CLEAR: begin
                    n_front = '0;
                    n_count = '0;
                end
                default: begin
                    // spare code: nothing changes
                end
            endcase
        end
    end

    // ring state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
        end else begin
            r_front <= n_front;
            r_count <= n_count;
        end
    end

    // outcome registers
    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_rd     <= n_rd;
    end

    // entry storage
    dq_ram #(
        .WIDTH (dq_pkg::WORD_W),
        .DEPTH (dq_pkg::CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (r_item),
        .o_rdata (ram_rdata)
    );

    // output register, freed when the beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_result <= r_rd ? ram_rdata : '0;
            r_out_status <= r_status;
            r_out_count  <= r_count;
            r_out_empty  <= empty;
        end
    end

    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_out_result;
    assign o_status       = r_out_status;
    assign o_entry_count  = r_out_count;
    assign o_is_empty     = r_out_empty;

`ifndef SYNTHESIS
    // count never passes the ring size
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(dq_pkg::CAPACITY))
        else $error("entry count above capacity");

    // ring state only moves on an execute step
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.exec |=> $stable(r_count) && $stable(r_front))
        else $error("ring state changed outside execute");

    // a result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || i_out_ready))
        else $error("output register overwritten");

    // a nonzero word only comes with an ok status
    a_word_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_result != '0) |-> r_out_status == dq_pkg::ST_OK)
        else $error("word returned with error status");

    // one ram access per cycle
    a_one_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re))
        else $error("ram read and write together");
`endif

endmodule

// ----- sv/double_ended_queue.sv -----
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded double-ended queue of 64-bit words held in a ring buffer.
//
//   channel | dir | payload                                         | beat
//   i_in    | in  | kind, item_value, position                      | valid & ready
//   o_out   | out | result_value, status, entry_count, is_empty     | valid & ready
//
// Each operation runs through accept, execute (one access of the
// single-port entry RAM), then transfer into the output register.
// The output register frees the input side: the next operation is accepted
// while a result still waits, and only its transfer stalls on o_out.ready.
// Synchronous active-low reset empties the queue; entry contents stay
// undefined until written and need no clearing pass.
// ----------------------------------------------------------------------------
module double_ended_queue (
    input  logic    i_clk,
    input  logic    i_rst_n,
    dq_in_if.sink   i_in,
    dq_out_if.source o_out
);

    dq_pkg::t_dq_cmd cmd;
    dq_pkg::t_dq_sts sts;
    logic            in_ready;

    // sequencer
    dq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    assign i_in.ready = in_ready;

    // ring datapath
    dq_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_kind         (i_in.kind),
        .i_item_value   (i_in.item_value),
        .i_position     (i_in.position),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_result_value (o_out.result_value),
        .o_status       (o_out.status),
        .o_entry_count  (o_out.entry_count),
        .o_is_empty     (o_out.is_empty)
    );

endmodule
